// ----- rtl/ctpc_pkg.sv -----
// Shared widths, register codes and the root-search step for the two-circle clamp.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ctpc_pkg;

    localparam int FRACTION_BITS = 4;
    localparam int CW            = 12;                     // centre register width
    localparam int RADW          = 10;                     // radius register width
    localparam int PW            = 13;                     // point coordinate width
    localparam int OUT_W         = 17;                     // clamped coordinate width
    localparam int AX_W          = 13;                     // |point - centre|
    localparam int DW            = 14;                     // signed difference
    localparam int D2_W          = 27;                     // squared distance
    localparam int R2_W          = 2 * RADW;
    localparam int RAX_W         = RADW + AX_W;
    localparam int X_W           = RAX_W + FRACTION_BITS + 1; // 2 * r * a * 2^F
    localparam int XX_W          = 2 * X_W;
    localparam int M_BITS        = RADW + FRACTION_BITS;   // offset magnitude bits
    localparam int P_W           = 44;                     // t * d2, signed
    localparam int REM_W         = 61;                     // X^2 - t^2 * d2, signed
    localparam int SUM_W         = OUT_W + 2;
    localparam int LAT           = M_BITS + 5;             // pipeline depth in stages

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_CX  = 3'd0,
        REG_LEFT_CY  = 3'd1,
        REG_RIGHT_CX = 3'd2,
        REG_RIGHT_CY = 3'd3,
        REG_RADIUS   = 3'd4
    } cfg_reg_t;

    localparam logic [CW-1:0]   RST_LEFT_CX  = 12'd300;
    localparam logic [CW-1:0]   RST_LEFT_CY  = 12'd225;
    localparam logic [CW-1:0]   RST_RIGHT_CX = 12'd500;
    localparam logic [CW-1:0]   RST_RIGHT_CY = 12'd225;
    localparam logic [RADW-1:0] RST_RADIUS   = 10'd56;

    typedef struct packed {
        logic signed [REM_W-1:0] rem;
        logic signed [P_W-1:0]   p;
        logic                    hit;
    } step_t;

    // One bit of the search for the largest m with (2m-1)^2 * d2 <= X^2.
    // Try setting bit k: t grows by 2^(k+1), so t^2*d2 grows by
    // 2^(k+2)*t*d2 + 2^(2k+2)*d2.
    function automatic step_t root_step(input logic signed [REM_W-1:0] rem,
                                        input logic signed [P_W-1:0]   p,
                                        input logic [D2_W-1:0]         d2,
                                        input int                      k);
        logic signed [REM_W-1:0] pe;
        logic signed [REM_W-1:0] de;
        logic signed [REM_W-1:0] term;
        logic signed [REM_W-1:0] nxt;
        step_t                   o;
        pe    = REM_W'(p);
        de    = $signed(REM_W'(d2));
        term  = (pe <<< (k + 2)) + (de <<< (2 * k + 2));
        nxt   = rem - term;
        o.hit = !nxt[REM_W-1];
        o.rem = o.hit ? nxt : rem;
        o.p   = o.hit ? p + $signed(P_W'(d2) << (k + 1)) : p;
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ctpc_if.sv -----
// Channel interfaces for the two-circle clamp: point input, result output, config write.
// Depends on ctpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ctpc_in_if import ctpc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] point_x;
    logic signed [PW-1:0] point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface ctpc_out_if import ctpc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] left_y;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic                    left_moved;
    logic                    right_moved;
    modport source (output valid, output left_x, output left_y, output right_x,
                    output right_y, output left_moved, output right_moved, input ready);
    modport sink   (input valid, input left_x, input left_y, input right_x,
                    input right_y, input left_moved, input right_moved, output ready);
endinterface

interface ctpc_cfg_if import ctpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/clamp_point_to_two_circles_unit.sv -----
// Top level of the two-circle point clamp: config registers, valid pipeline, two lanes.
// Depends on ctpc_pkg, ctpc_if (channel interfaces) and ctpc_lane.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | payload                                          | item
//  --------+-----+--------------------------------------------------+--------------------
//  in_ch   | in  | point_x, point_y (s13 pixels)                    | one point
//  out_ch  | out | left_x/y, right_x/y (s17 Q12.4), left/right_moved | one clamped pair
//  cfg_ch  | in  | index (3 b), data (12 b)                         | one register write
//
//  Depth is LAT stages: three arithmetic stages, a seed stage, fourteen search stages
//  (one offset bit each) and the output register. One item per cycle while not stalled.
//  Reset clears the valid bits and loads the default centres and radius.
//  A stalled result holds the whole pipeline; nothing is dropped or repeated.
//  cfg_ch is always ready; write it only while no item is in flight.

module clamp_point_to_two_circles_unit import ctpc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    ctpc_in_if.sink    in_ch,
    ctpc_out_if.source out_ch,
    ctpc_cfg_if.sink   cfg_ch
);

    // configuration registers
    logic [CW-1:0]   lcx_reg, lcy_reg, rcx_reg, rcy_reg;
    logic [RADW-1:0] rad_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcx_reg <= RST_LEFT_CX;
            lcy_reg <= RST_LEFT_CY;
            rcx_reg <= RST_RIGHT_CX;
            rcy_reg <= RST_RIGHT_CY;
            rad_reg <= RST_RADIUS;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_LEFT_CX:  lcx_reg <= cfg_ch.data;
                REG_LEFT_CY:  lcy_reg <= cfg_ch.data;
                REG_RIGHT_CX: rcx_reg <= cfg_ch.data;
                REG_RIGHT_CY: rcy_reg <= cfg_ch.data;
                REG_RADIUS:   rad_reg <= cfg_ch.data[RADW-1:0];
                default:      ;   // drop writes past the last register
            endcase
        end
    end

    // valid bits travel beside the lane data; advance everything unless the
    // output holds an item that is not being taken
    logic           adv;
    logic [LAT-1:0] v_reg;

    assign adv         = !v_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[LAT-2:0], in_ch.valid};
    end

    // one lane per circle; both see the same point
    ctpc_lane u_left (
        .clk      (clk),
        .en       (adv),
        .point_x  (in_ch.point_x),
        .point_y  (in_ch.point_y),
        .center_x (lcx_reg),
        .center_y (lcy_reg),
        .radius   (rad_reg),
        .clamp_x  (out_ch.left_x),
        .clamp_y  (out_ch.left_y),
        .moved    (out_ch.left_moved)
    );

    ctpc_lane u_right (
        .clk      (clk),
        .en       (adv),
        .point_x  (in_ch.point_x),
        .point_y  (in_ch.point_y),
        .center_x (rcx_reg),
        .center_y (rcy_reg),
        .radius   (rad_reg),
        .clamp_x  (out_ch.right_x),
        .clamp_y  (out_ch.right_y),
        .moved    (out_ch.right_moved)
    );

    // an accepted item occupies the first stage on the next cycle
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> v_reg[0])
        else $error("accepted item missing from first stage");

    // a held result freezes the pipeline: no new item may enter
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted while output stalled");

    // a stalled pipeline keeps its occupancy
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> ($countones(v_reg) == $past($countones(v_reg))))
        else $error("item lost or created during stall");

endmodule

`default_nettype wire

// ----- rtl/ctpc_lane.sv -----
// Datapath for one circle: distance, inside test, bit-per-stage root search, saturation.
// Depends on ctpc_pkg; advances whenever en is high.
`timescale 1ns / 1ps
`default_nettype none

module ctpc_lane import ctpc_pkg::*; (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [PW-1:0]    point_x,
    input  logic signed [PW-1:0]    point_y,
    input  logic [CW-1:0]           center_x,
    input  logic [CW-1:0]           center_y,
    input  logic [RADW-1:0]         radius,
    output logic signed [OUT_W-1:0] clamp_x,
    output logic signed [OUT_W-1:0] clamp_y,
    output logic                    moved
);

    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic                 sx;
        logic                 sy;
        logic                 in_circle;
        logic [D2_W-1:0]      d2;
    } carry_t;

    // stage A: differences and r*|d|
    logic signed [PW-1:0]  pxa_reg, pya_reg;
    logic                  sxa_reg, sya_reg;
    logic [AX_W-1:0]       axa_reg, aya_reg;
    logic [RAX_W-1:0]      rxa_reg, rya_reg;
    logic [RADW-1:0]       ra_reg;
    logic signed [DW-1:0]  dx_next, dy_next;
    logic [DW-1:0]         adx, ady;

    assign dx_next = DW'(point_x) - $signed({2'b00, center_x});
    assign dy_next = DW'(point_y) - $signed({2'b00, center_y});
    assign adx     = dx_next[DW-1] ? DW'(-dx_next) : DW'(dx_next);
    assign ady     = dy_next[DW-1] ? DW'(-dy_next) : DW'(dy_next);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxa_reg <= point_x;
            pya_reg <= point_y;
            sxa_reg <= dx_next[DW-1];
            sya_reg <= dy_next[DW-1];
            axa_reg <= adx[AX_W-1:0];
            aya_reg <= ady[AX_W-1:0];
            rxa_reg <= RAX_W'(radius) * RAX_W'(adx[AX_W-1:0]);
            rya_reg <= RAX_W'(radius) * RAX_W'(ady[AX_W-1:0]);
            ra_reg  <= radius;
        end
    end

    // stage B: squared distance, scaled numerators, r^2
    logic signed [PW-1:0] pxb_reg, pyb_reg;
    logic                 sxb_reg, syb_reg;
    logic [D2_W-1:0]      d2b_reg;
    logic [X_W-1:0]       xb_reg, yb_reg;
    logic [R2_W-1:0]      r2b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxb_reg <= pxa_reg;
            pyb_reg <= pya_reg;
            sxb_reg <= sxa_reg;
            syb_reg <= sya_reg;
            d2b_reg <= D2_W'(axa_reg) * D2_W'(axa_reg) + D2_W'(aya_reg) * D2_W'(aya_reg);
            xb_reg  <= {rxa_reg, {(FRACTION_BITS + 1){1'b0}}};
            yb_reg  <= {rya_reg, {(FRACTION_BITS + 1){1'b0}}};
            r2b_reg <= R2_W'(ra_reg) * R2_W'(ra_reg);
        end
    end

    // stage C: squares of the numerators, inside test
    carry_t           cc_reg;
    logic [XX_W-1:0]  xxc_reg, yyc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg.px        <= pxb_reg;
            cc_reg.py        <= pyb_reg;
            cc_reg.sx        <= sxb_reg;
            cc_reg.sy        <= syb_reg;
            cc_reg.d2        <= d2b_reg;
            cc_reg.in_circle <= d2b_reg <= D2_W'(r2b_reg);
            xxc_reg          <= XX_W'(xb_reg) * XX_W'(xb_reg);
            yyc_reg          <= XX_W'(yb_reg) * XX_W'(yb_reg);
        end
    end

    // stage D and search stages: index 0 is the seed, index s+1 follows bit M_BITS-1-s
    carry_t                   car_reg  [0:M_BITS];
    logic signed [REM_W-1:0]  remx_reg [0:M_BITS];
    logic signed [REM_W-1:0]  remy_reg [0:M_BITS];
    logic signed [P_W-1:0]    px_reg   [0:M_BITS];
    logic signed [P_W-1:0]    py_reg   [0:M_BITS];
    logic [M_BITS-1:0]        mx_reg   [0:M_BITS];
    logic [M_BITS-1:0]        my_reg   [0:M_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            car_reg[0]  <= cc_reg;
            remx_reg[0] <= $signed(REM_W'(xxc_reg)) - $signed(REM_W'(cc_reg.d2));
            remy_reg[0] <= $signed(REM_W'(yyc_reg)) - $signed(REM_W'(cc_reg.d2));
            px_reg[0]   <= -$signed(P_W'(cc_reg.d2));
            py_reg[0]   <= -$signed(P_W'(cc_reg.d2));
            mx_reg[0]   <= '0;
            my_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < M_BITS; s++)
    begin : g_search
        localparam int K = M_BITS - 1 - s;
        step_t stx, sty;

        assign stx = root_step(remx_reg[s], px_reg[s], car_reg[s].d2, K);
        assign sty = root_step(remy_reg[s], py_reg[s], car_reg[s].d2, K);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                car_reg[s+1]  <= car_reg[s];
                remx_reg[s+1] <= stx.rem;
                remy_reg[s+1] <= sty.rem;
                px_reg[s+1]   <= stx.p;
                py_reg[s+1]   <= sty.p;
                mx_reg[s+1]   <= mx_reg[s] | (M_BITS'(stx.hit) << K);
                my_reg[s+1]   <= my_reg[s] | (M_BITS'(sty.hit) << K);
            end
        end
    end

    // final stage: centre plus signed offset, saturate, or pass the point through
    logic signed [SUM_W-1:0] bx, by, ox, oy, sumx, sumy;
    logic signed [OUT_W-1:0] satx, saty;
    carry_t                  cf;

    assign cf   = car_reg[M_BITS];
    assign bx   = $signed({3'b000, center_x, {FRACTION_BITS{1'b0}}});
    assign by   = $signed({3'b000, center_y, {FRACTION_BITS{1'b0}}});
    assign ox   = $signed(SUM_W'(mx_reg[M_BITS]));
    assign oy   = $signed(SUM_W'(my_reg[M_BITS]));
    assign sumx = cf.sx ? bx - ox : bx + ox;
    assign sumy = cf.sy ? by - oy : by + oy;

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 << (OUT_W - 1)) - 1);
        lo = -SUM_W'(1 << (OUT_W - 1));
        if (v > hi)
            return hi[OUT_W-1:0];
        else if (v < lo)
            return lo[OUT_W-1:0];
        else
            return v[OUT_W-1:0];
    endfunction

    assign satx = sat(sumx);
    assign saty = sat(sumy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_x <= cf.in_circle ? {cf.px, {FRACTION_BITS{1'b0}}} : satx;
            clamp_y <= cf.in_circle ? {cf.py, {FRACTION_BITS{1'b0}}} : saty;
            moved   <= !cf.in_circle;
        end
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for clamp_point_to_two_circles_unit: streams points, predicts both
// clamped positions in fixed point and compares each result item. Depends on ctpc_pkg,
// the channel interfaces in rtl/ctpc_if.sv and the RTL top level.
`timescale 1ns / 1ps

module testbench;
    import ctpc_pkg::*;

    // Named codes the package does not give: an index past the last register.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 250;
    localparam int RANDOM_ITEMS = 1700;

    typedef struct {
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] left_y;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] right_y;
        logic                    left_moved;
        logic                    right_moved;
    } clamp_result_t;

    // One row of the directed table; typed rows carry their expected item.
    typedef struct {
        int            px;
        int            py;
        bit            typed;
        clamp_result_t res;
    } point_row_t;

    logic clk;
    logic rst_n;

    ctpc_in_if  in_ch ();
    ctpc_out_if out_ch ();
    ctpc_cfg_if cfg_ch ();

    clamp_point_to_two_circles_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Register copies as the block should hold them
    logic [CW-1:0]   left_cx, left_cy, right_cx, right_cy;
    logic [RADW-1:0] radius;

    clamp_result_t pending_clamps[$];
    int            failures;
    int            burst_left;
    bit            flood;       // sender offers back to back while set
    bit            hold_req;    // ask the receiver for one long hold-off
    int            hold_cnt;
    int            stall_mode;
    int            stall_tick;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Nearest integer to r*mag*2^F/sqrt(d2), halves away from zero, by bisection on
    // (2m-1)^2 <= (2*r*mag*2^F)^2 / d2.
    function automatic longint unsigned offset_magnitude(input longint unsigned r,
                                                         input longint unsigned mag,
                                                         input longint unsigned d2);
        longint unsigned twice, q, lo, hi, mid, s;
        twice = 2 * r * mag * (64'd1 << FRACTION_BITS);
        q     = (twice * twice) / d2;
        lo    = 0;
        hi    = r * (64'd1 << FRACTION_BITS);
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            s   = (2 * mid - 1) * (2 * mid - 1);
            if (s <= q)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [OUT_W-1:0] saturate(input longint v);
        if (v > 65535)
            return 17'sd65535;
        if (v < -65536)
            return -17'sd65536;
        return v[OUT_W-1:0];
    endfunction

    // Clamp one point into one circle of the current radius
    function automatic void clamp_to_circle(input longint px, input longint py,
                                            input longint cx, input longint cy,
                                            output logic signed [OUT_W-1:0] ox,
                                            output logic signed [OUT_W-1:0] oy,
                                            output logic moved);
        longint          dx, dy, mx, my;
        longint unsigned ax, ay, d2, r;
        dx = px - cx;
        dy = py - cy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        d2 = ax * ax + ay * ay;
        r  = radius;
        if (d2 <= r * r) begin
            ox    = saturate(px <<< FRACTION_BITS);
            oy    = saturate(py <<< FRACTION_BITS);
            moved = 1'b0;
        end
        else begin
            mx    = offset_magnitude(r, ax, d2);
            my    = offset_magnitude(r, ay, d2);
            ox    = saturate((cx <<< FRACTION_BITS) + ((dx < 0) ? -mx : mx));
            oy    = saturate((cy <<< FRACTION_BITS) + ((dy < 0) ? -my : my));
            moved = 1'b1;
        end
    endfunction

    function automatic clamp_result_t predict_clamps(input longint px, input longint py);
        clamp_result_t res;
        clamp_to_circle(px, py, left_cx, left_cy, res.left_x, res.left_y, res.left_moved);
        clamp_to_circle(px, py, right_cx, right_cy, res.right_x, res.right_y,
                        res.right_moved);
        return res;
    endfunction

    // Offer one point; idle first when the current burst is spent and flood is clear.
    task automatic offer_point(input int px, input int py, input bit typed,
                               input clamp_result_t typed_res);
        int gap;
        if (burst_left == 0 && !flood) begin
            gap = $urandom_range(0, 9);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= px[PW-1:0];
        in_ch.point_y <= py[PW-1:0];
        do
            @(posedge clk);
        while (!in_ch.ready);
        // Registers are frozen while items are in flight, so predict at acceptance
        pending_clamps.push_back(typed ? typed_res : predict_clamps(px, py));
    endtask

    // Hold valid high across consecutive writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_LEFT_CX:  left_cx  = value[CW-1:0];
            REG_LEFT_CY:  left_cy  = value[CW-1:0];
            REG_RIGHT_CX: right_cx = value[CW-1:0];
            REG_RIGHT_CY: right_cy = value[CW-1:0];
            REG_RADIUS:   radius   = value[RADW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int lcx, input int lcy, input int rcx, input int rcy,
                             input int rad);
        write_reg(REG_LEFT_CX, lcx);
        write_reg(REG_LEFT_CY, lcy);
        write_reg(REG_RIGHT_CX, rcx);
        write_reg(REG_RIGHT_CY, rcy);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_UNUSED, $urandom_range(0, 4095));
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and let the pipeline drain before touching the registers
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_clamps.size() != 0);
        repeat (LAT + 2) @(posedge clk);
    endtask

    // Random point: mostly near one centre so both sides of the boundary are hit
    task automatic offer_random(input int count);
        int kind, cx, cy, r, px, py, dir;
        clamp_result_t none;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 1)) begin
                cx = left_cx;
                cy = left_cy;
            end
            else begin
                cx = right_cx;
                cy = right_cy;
            end
            r = radius;
            if (kind < 3) begin
                px = $urandom_range(0, 8191) - 4096;
                py = $urandom_range(0, 8191) - 4096;
            end
            else if (kind < 5) begin
                // exactly on the circle along an axis
                dir = $urandom_range(0, 3);
                px  = cx + ((dir == 0) ? r : (dir == 1) ? -r : 0);
                py  = cy + ((dir == 2) ? r : (dir == 3) ? -r : 0);
            end
            else begin
                px = cx + $urandom_range(0, 2 * r + 8) - (r + 4);
                py = cy + $urandom_range(0, 2 * r + 8) - (r + 4);
            end
            if (px > 4095 || py > 4095) begin
                px = $urandom_range(0, 8191) - 4096;
                py = $urandom_range(0, 8191) - 4096;
            end
            offer_point(px, py, 1'b0, none);
        end
    endtask

    // Receiver: stall on a changing pattern, honour the long hold-off, check items.
    always @(posedge clk or negedge rst_n) begin
        clamp_result_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cnt   = 0;
            stall_mode = 0;
            stall_tick = 0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_clamps.size() == 0) begin
                    $display("%0t: result item with nothing expected", $time);
                    failures++;
                end
                else begin
                    want = pending_clamps.pop_front();
                    if (out_ch.left_x !== want.left_x) begin
                        $display("%0t: left_x expected %0d actual %0d", $time,
                                 want.left_x, out_ch.left_x);
                        failures++;
                    end
                    if (out_ch.left_y !== want.left_y) begin
                        $display("%0t: left_y expected %0d actual %0d", $time,
                                 want.left_y, out_ch.left_y);
                        failures++;
                    end
                    if (out_ch.right_x !== want.right_x) begin
                        $display("%0t: right_x expected %0d actual %0d", $time,
                                 want.right_x, out_ch.right_x);
                        failures++;
                    end
                    if (out_ch.right_y !== want.right_y) begin
                        $display("%0t: right_y expected %0d actual %0d", $time,
                                 want.right_y, out_ch.right_y);
                        failures++;
                    end
                    if (out_ch.left_moved !== want.left_moved) begin
                        $display("%0t: left_moved expected %0b actual %0b", $time,
                                 want.left_moved, out_ch.left_moved);
                        failures++;
                    end
                    if (out_ch.right_moved !== want.right_moved) begin
                        $display("%0t: right_moved expected %0b actual %0b", $time,
                                 want.right_moved, out_ch.right_moved);
                        failures++;
                    end
                end
            end
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 9) < 7);
                    2:       out_ch.ready <= (stall_tick % 5 != 0);
                    default: out_ch.ready <= ($urandom_range(0, 9) < 3);
                endcase
        end
    end

    // Stimulus
    initial begin
        point_row_t    rows[$];
        point_row_t    row;
        clamp_result_t none;
        failures   = 0;
        burst_left = 0;
        flood      = 1'b0;
        hold_req   = 1'b0;
        left_cx    = RST_LEFT_CX;
        left_cy    = RST_LEFT_CY;
        right_cx   = RST_RIGHT_CX;
        right_cy   = RST_RIGHT_CY;
        radius     = RST_RADIUS;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_LEFT_CX;
        cfg_ch.data   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table with the reset geometry. Typed rows: a point at the left
        // centre stays put there and lands 56 px left of the right centre; a point
        // midway is pulled onto both circles.
        rows.push_back('{300, 225, 1'b1, '{4800, 3600, 7104, 3600, 1'b0, 1'b1}});
        rows.push_back('{400, 225, 1'b1, '{5696, 3600, 7104, 3600, 1'b1, 1'b1}});
        rows.push_back('{-4096, -4096, 1'b0, none});
        rows.push_back('{4095, 4095, 1'b0, none});
        rows.push_back('{-4096, 4095, 1'b0, none});
        rows.push_back('{4095, -4096, 1'b0, none});
        rows.push_back('{0, 0, 1'b0, none});
        rows.push_back('{-1, -1, 1'b0, none});
        rows.push_back('{356, 225, 1'b0, none});   // on the left circle: stays
        rows.push_back('{357, 225, 1'b0, none});   // just past it: moves
        rows.push_back('{300, 169, 1'b0, none});
        rows.push_back('{444, 225, 1'b0, none});   // on the right circle
        rows.push_back('{333, 269, 1'b0, none});   // 3-4-5 triangle, distance 55
        rows.push_back('{340, 255, 1'b0, none});   // distance 50
        rows.push_back('{335, 190, 1'b0, none});   // diagonal, rounding of halves
        rows.push_back('{500, 4095, 1'b0, none});
        rows.push_back('{2730, -1365, 1'b0, none});
        foreach (rows[i]) begin
            row = rows[i];
            offer_point(row.px, row.py, row.typed, row.res);
        end
        drain();

        // Extreme centres with the largest radius, corner points first
        configure(4095, 4095, 0, 0, 1023);
        offer_point(-4096, -4096, 1'b0, none);
        offer_point(4095, 4095, 1'b0, none);
        offer_point(4095, -4096, 1'b0, none);
        offer_point(-4096, 4095, 1'b0, none);
        offer_point(3072, 3072, 1'b0, none);
        offer_random(250);
        drain();

        // Zero radius: anything off the centre collapses onto it
        configure(0, 4095, 4095, 0, 0);
        offer_point(0, 4095, 1'b0, none);
        offer_point(4095, 0, 1'b0, none);
        offer_point(1, 4095, 1'b0, none);
        offer_random(200);
        drain();

        // Radius written with bits above its width: only the low ten bits count.
        // Flood the input while the receiver holds off so the pipeline backs up.
        configure(1234, 2345, 3456, 567, 12'hBC7);
        flood    = 1'b1;
        hold_req = 1'b1;
        offer_random(300);
        flood = 1'b0;
        offer_random(100);
        drain();

        // Random settings, small radii mostly
        repeat (4) begin
            configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, 64));
            offer_random((RANDOM_ITEMS - 850) / 4);
            drain();
        end

        // Back to the reset geometry for the tail
        configure(RST_LEFT_CX, RST_LEFT_CY, RST_RIGHT_CX, RST_RIGHT_CY, RST_RADIUS);
        offer_random(2 * LAT);
        drain();

        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ctpc_pkg.sv
rtl/ctpc_if.sv
rtl/ctpc_lane.sv
rtl/clamp_point_to_two_circles_unit.sv
tb/testbench.sv
